[src/ais_pkg.sv]
// Package for the ascending integer sorter.
// Holds sizing constants and the cell control struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ais_pkg;

  // Number of cells in the insertion chain (range 2..64)
  localparam int MAX_ELEMS = 64;
  localparam int DATA_W    = 32;
  // Fill count must be able to hold MAX_ELEMS itself
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value into the sorted chain
    logic drain;   // shift every cell toward the head by one
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/ais_cell.sv]
// One cell of the sorting chain: holds a value and an occupied bit.
// Depends on ais_pkg for the data width and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module ais_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ais_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [ais_pkg::DATA_W-1:0] new_value,
  // neighbor toward the head (smaller values)
  input  wire logic signed [ais_pkg::DATA_W-1:0] left_value,
  input  wire logic                              left_occ,
  input  wire logic                              left_greater,
  // neighbor toward the tail (larger values)
  input  wire logic signed [ais_pkg::DATA_W-1:0] right_value,
  input  wire logic                              right_occ,
  output logic signed [ais_pkg::DATA_W-1:0]      cell_value,
  output logic                                   occ,
  output logic                                   greater
);

  // Empty cells count as greater, so the flag is monotonic along the chain
  assign greater = !occ || (cell_value > new_value);

  // Stored value: on insert, either shift in from the left or take the new value
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (greater) begin
        cell_value <= left_greater ? left_value : new_value;
      end
    end else if (ctrl.drain) begin
      cell_value <= right_value;
    end
  end

  // Occupied bit: grows by one cell on insert, shrinks by one on drain
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.insert) begin
      occ <= occ | left_occ;
    end else if (ctrl.drain) begin
      occ <= right_occ;
    end
  end

endmodule

`default_nettype wire

[src/ascending_integer_sorter.sv]
// Ascending integer sorter: top level with the cell chain and output register.
// Depends on ais_pkg and ais_cell.
//
// Usage:
//   Input channel (in_valid/in_ready, value, is_last) takes one signed value per
//   transaction, one per cycle while collecting. Each value is inserted at once
//   into a chain of MAX_ELEMS cells that stays sorted. Values beyond capacity are
//   dropped and flag overflow on every result of that run.
//   The transaction with is_last set ends the run. Output channel (out_valid/
//   out_ready, sorted_value, end_of_run, overflow) then gives the values in
//   ascending order, one per cycle while out_ready is high, end_of_run set on
//   the last one. After the is_last transaction the state register enters
//   drain, and the head cell then feeds the first result into the output
//   register. The drain goes through the single head cell feeding the output
//   register. in_ready is low while the chain drains, and goes high again
//   as the last result moves into the output register.
//   A stalled receiver holds the output register and freezes the drain.
//   Reset (rst, synchronous) empties the chain, clears out_valid and the drop
//   flag; end_of_run and overflow are not reset. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ascending_integer_sorter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [ais_pkg::DATA_W-1:0] value,
  input  wire logic                              is_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ais_pkg::DATA_W-1:0]      sorted_value,
  output logic                                   end_of_run,
  output logic                                   overflow
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic                     state;
  logic [ais_pkg::CNT_W-1:0] count;
  logic                     dropped;
  ais_pkg::cell_ctrl_t      ctrl;
  logic                     in_fire;
  logic                     load;
  logic                     full;

  logic signed [ais_pkg::DATA_W-1:0] cval [ais_pkg::MAX_ELEMS];
  logic                              cocc [ais_pkg::MAX_ELEMS];
  logic                              cgt  [ais_pkg::MAX_ELEMS];

  assign full     = (count == ais_pkg::CNT_W'(ais_pkg::MAX_ELEMS));
  assign in_ready = (state == ST_COLLECT);
  assign in_fire  = in_valid && in_ready;
  assign load     = (state == ST_DRAIN) && (!out_valid || out_ready);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.drain  = load;

  // Insertion chain
  for (genvar i = 0; i < ais_pkg::MAX_ELEMS; i++) begin : g_cell
    logic signed [ais_pkg::DATA_W-1:0] lval;
    logic                              locc;
    logic                              lgt;
    logic signed [ais_pkg::DATA_W-1:0] rval;
    logic                              rocc;

    if (i == 0) begin : g_head
      assign lval = value;
      assign locc = 1'b1;
      assign lgt  = 1'b0;
    end else begin : g_body
      assign lval = cval[i-1];
      assign locc = cocc[i-1];
      assign lgt  = cgt[i-1];
    end

    if (i == ais_pkg::MAX_ELEMS - 1) begin : g_tail
      assign rval = value;
      assign rocc = 1'b0;
    end else begin : g_mid
      assign rval = cval[i+1];
      assign rocc = cocc[i+1];
    end

    ais_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_value    (value),
      .left_value   (lval),
      .left_occ     (locc),
      .left_greater (lgt),
      .right_value  (rval),
      .right_occ    (rocc),
      .cell_value   (cval[i]),
      .occ          (cocc[i]),
      .greater      (cgt[i])
    );
  end

  // Run control: fill count, drop flag and collect/drain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_COLLECT;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (in_fire) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (is_last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (load) begin
            count <= count - 1'b1;
            if (count == ais_pkg::CNT_W'(1)) begin
              state   <= ST_COLLECT;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // Output register, fed from the head cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sorted_value <= cval[0];
      end_of_run   <= (count == ais_pkg::CNT_W'(1));
      overflow     <= dropped;
    end
  end

  // While draining, the head cell always holds a value
  a_head_occupied: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> cocc[0])
    else $error("drain with empty head cell");

  // Fill count and head occupancy agree
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !cocc[0])
    else $error("empty count but head cell occupied");

  // Loading the final result of a run returns to collecting
  a_end_collect: assert property (@(posedge clk) disable iff (rst)
    (load && count == ais_pkg::CNT_W'(1)) |=> (state == ST_COLLECT && end_of_run))
    else $error("run did not end after final result");

  // The fill count never exceeds the chain length
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= ais_pkg::CNT_W'(ais_pkg::MAX_ELEMS))
    else $error("fill count beyond capacity");

endmodule

`default_nettype wire
